[src/llsp_pkg.sv]
package llsp_pkg;

    localparam int ID_BITS = 6;

    localparam logic CMD_SYNC = 1'b0;
    localparam logic CMD_PICK = 1'b1;

    typedef enum logic [1:0]
    {
        OP_NONE = 2'd0,
        OP_SYNC = 2'd1,
        OP_BUMP = 2'd2
    } wr_op_t;

    typedef enum logic [1:0]
    {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    typedef struct packed
    {
        logic tok;
        logic have;
    } cand_ctl_t;

endpackage

[src/llsp_cell.sv]
module llsp_cell #(
    parameter int CELL_ID     = 0,
    parameter int IDX_W       = 6,
    parameter int TYPE_BITS   = 16,
    parameter int LOAD_BITS   = 20,
    parameter int HANDLE_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  llsp_pkg::wr_op_t          wr_op,
    input  logic [llsp_pkg::ID_BITS-1:0] wr_id,
    input  logic [TYPE_BITS-1:0]      wr_type,
    input  logic [LOAD_BITS-1:0]      wr_load,
    input  logic [HANDLE_BITS-1:0]    wr_link,
    input  logic [TYPE_BITS-1:0]      query,
    input  llsp_pkg::cand_ctl_t       in_ctl,
    input  logic [IDX_W-1:0]          in_id,
    input  logic [TYPE_BITS-1:0]      in_type,
    input  logic [LOAD_BITS-1:0]      in_load,
    input  logic [HANDLE_BITS-1:0]    in_link,
    output llsp_pkg::cand_ctl_t       out_ctl,
    output logic [IDX_W-1:0]          out_id,
    output logic [TYPE_BITS-1:0]      out_type,
    output logic [LOAD_BITS-1:0]      out_load,
    output logic [HANDLE_BITS-1:0]    out_link
);
    import llsp_pkg::*;

    logic                   valid_reg;
    logic [TYPE_BITS-1:0]   type_reg;
    logic [LOAD_BITS-1:0]   load_reg;
    logic [HANDLE_BITS-1:0] link_reg;

    cand_ctl_t              ctl_reg, ctl_next;
    logic [IDX_W-1:0]       id_reg, id_next;
    logic [TYPE_BITS-1:0]   ctype_reg, ctype_next;
    logic [LOAD_BITS-1:0]   cload_reg, cload_next;
    logic [HANDLE_BITS-1:0] clink_reg, clink_next;

    logic hit;
    logic match;
    logic take;

    assign hit   = (wr_op != OP_NONE) && (32'(wr_id) == CELL_ID);
    assign match = valid_reg && (|(type_reg & query));
    assign take  = in_ctl.tok && match && (!in_ctl.have || (load_reg < in_load));

    always_comb
    begin
        ctl_next.tok  = in_ctl.tok;
        ctl_next.have = in_ctl.have | (in_ctl.tok & match);
        if (take)
        begin
            id_next    = IDX_W'(CELL_ID);
            ctype_next = type_reg;
            cload_next = load_reg;
            clink_next = link_reg;
        end
        else
        begin
            id_next    = in_id;
            ctype_next = in_type;
            cload_next = in_load;
            clink_next = in_link;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ctl_reg   <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
            if (hit && (wr_op == OP_SYNC))
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        ctype_reg <= ctype_next;
        cload_reg <= cload_next;
        clink_reg <= clink_next;
        if (hit)
        begin
            load_reg <= wr_load;
            if (wr_op == OP_SYNC)
            begin
                link_reg <= wr_link;
                if (!valid_reg)
                begin
                    type_reg <= wr_type;
                end
            end
        end
    end

    assign out_ctl  = ctl_reg;
    assign out_id   = id_reg;
    assign out_type = ctype_reg;
    assign out_load = cload_reg;
    assign out_link = clink_reg;

endmodule

[src/least_loaded_server_picker_top.sv]
// Least-loaded server picker.
// Command channel: a word is taken at a rising edge with start high and busy
// low. command selects sync (record load and link handle under server_id, and
// type if not yet valid) or pick (choose the valid server matching type_mask
// with least load, lowest id on ties, and bump its load by one, saturating).
// Result channel: done is high for exactly one cycle with found and the
// chosen_* fields; the receiver takes it in that cycle and cannot stall it.
// A sync gives no result and busy stays low: a new word is taken every cycle.
// A pick sends a candidate token down a chain of TABLE_DEPTH cells, one cell
// per cycle; done rises and busy falls in the same cycle, after the token
// leaves the last cell, so no new word is taken while a pick is running.
// The chain length sets how long a pick keeps the block busy.
// The load bump of the chosen entry lands at the end of the done cycle, in
// time for any following word.
// Reset clears every valid mark at once; the block takes words right after.
module least_loaded_server_picker_top #(
    parameter int TABLE_DEPTH = 64,
    parameter int TYPE_BITS   = 16,
    parameter int LOAD_BITS   = 20,
    parameter int HANDLE_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         command,
    input  logic [llsp_pkg::ID_BITS-1:0] server_id,
    input  logic [TYPE_BITS-1:0]         type_mask,
    input  logic [LOAD_BITS-1:0]         load_count,
    input  logic [HANDLE_BITS-1:0]       link_handle,
    output logic                         done,
    output logic                         found,
    output logic [llsp_pkg::ID_BITS-1:0] chosen_id,
    output logic [TYPE_BITS-1:0]         chosen_type,
    output logic [LOAD_BITS-1:0]         chosen_load,
    output logic [HANDLE_BITS-1:0]       chosen_link
);
    import llsp_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    state_t                 state_reg, state_next;
    logic                   launch_reg, launch_next;
    logic [TYPE_BITS-1:0]   query_reg, query_next;

    wr_op_t                 wr_op_reg, wr_op_next;
    logic [ID_BITS-1:0]     wr_id_reg, wr_id_next;
    logic [TYPE_BITS-1:0]   wr_type_reg, wr_type_next;
    logic [LOAD_BITS-1:0]   wr_load_reg, wr_load_next;
    logic [HANDLE_BITS-1:0] wr_link_reg, wr_link_next;

    logic                   done_reg, done_next;
    logic                   found_reg, found_next;
    logic [ID_BITS-1:0]     cid_reg, cid_next;
    logic [TYPE_BITS-1:0]   ctype_reg, ctype_next;
    logic [LOAD_BITS-1:0]   cload_reg, cload_next;
    logic [HANDLE_BITS-1:0] clink_reg, clink_next;

    cand_ctl_t              ctl_chain  [TABLE_DEPTH+1];
    logic [IDX_W-1:0]       id_chain   [TABLE_DEPTH+1];
    logic [TYPE_BITS-1:0]   type_chain [TABLE_DEPTH+1];
    logic [LOAD_BITS-1:0]   load_chain [TABLE_DEPTH+1];
    logic [HANDLE_BITS-1:0] link_chain [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0] tok_vec;

    logic                   accept;
    logic [LOAD_BITS-1:0]   bumped;

    assign accept = start && !busy;

    assign ctl_chain[0].tok  = launch_reg;
    assign ctl_chain[0].have = 1'b0;
    assign id_chain[0]       = '0;
    assign type_chain[0]     = '0;
    assign load_chain[0]     = '0;
    assign link_chain[0]     = '0;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            llsp_cell #(
                .CELL_ID     (gi),
                .IDX_W       (IDX_W),
                .TYPE_BITS   (TYPE_BITS),
                .LOAD_BITS   (LOAD_BITS),
                .HANDLE_BITS (HANDLE_BITS)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .wr_op    (wr_op_reg),
                .wr_id    (wr_id_reg),
                .wr_type  (wr_type_reg),
                .wr_load  (wr_load_reg),
                .wr_link  (wr_link_reg),
                .query    (query_reg),
                .in_ctl   (ctl_chain[gi]),
                .in_id    (id_chain[gi]),
                .in_type  (type_chain[gi]),
                .in_load  (load_chain[gi]),
                .in_link  (link_chain[gi]),
                .out_ctl  (ctl_chain[gi+1]),
                .out_id   (id_chain[gi+1]),
                .out_type (type_chain[gi+1]),
                .out_load (load_chain[gi+1]),
                .out_link (link_chain[gi+1])
            );
            assign tok_vec[gi] = ctl_chain[gi+1].tok;
        end
    endgenerate

    assign bumped = (load_chain[TABLE_DEPTH] == {LOAD_BITS{1'b1}}) ?
                    load_chain[TABLE_DEPTH] : load_chain[TABLE_DEPTH] + LOAD_BITS'(1);

    always_comb
    begin
        state_next   = state_reg;
        launch_next  = 1'b0;
        query_next   = query_reg;
        wr_op_next   = OP_NONE;
        wr_id_next   = wr_id_reg;
        wr_type_next = wr_type_reg;
        wr_load_next = wr_load_reg;
        wr_link_next = wr_link_reg;
        done_next    = 1'b0;
        found_next   = found_reg;
        cid_next     = cid_reg;
        ctype_next   = ctype_reg;
        cload_next   = cload_reg;
        clink_next   = clink_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_PICK)
                    begin
                        state_next  = ST_SCAN;
                        launch_next = 1'b1;
                        query_next  = type_mask;
                    end
                    else
                    begin
                        wr_op_next   = OP_SYNC;
                        wr_id_next   = server_id;
                        wr_type_next = type_mask;
                        wr_load_next = load_count;
                        wr_link_next = link_handle;
                    end
                end
            end
            ST_SCAN:
            begin
                if (ctl_chain[TABLE_DEPTH].tok)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    if (ctl_chain[TABLE_DEPTH].have)
                    begin
                        found_next   = 1'b1;
                        cid_next     = ID_BITS'(id_chain[TABLE_DEPTH]);
                        ctype_next   = type_chain[TABLE_DEPTH];
                        cload_next   = bumped;
                        clink_next   = link_chain[TABLE_DEPTH];
                        wr_op_next   = OP_BUMP;
                        wr_id_next   = ID_BITS'(id_chain[TABLE_DEPTH]);
                        wr_load_next = bumped;
                    end
                    else
                    begin
                        found_next = 1'b0;
                        cid_next   = '0;
                        ctype_next = '0;
                        cload_next = '0;
                        clink_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            launch_reg <= 1'b0;
            wr_op_reg  <= OP_NONE;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            wr_op_reg  <= wr_op_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        query_reg   <= query_next;
        wr_id_reg   <= wr_id_next;
        wr_type_reg <= wr_type_next;
        wr_load_reg <= wr_load_next;
        wr_link_reg <= wr_link_next;
        found_reg   <= found_next;
        cid_reg     <= cid_next;
        ctype_reg   <= ctype_next;
        cload_reg   <= cload_next;
        clink_reg   <= clink_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign found       = found_reg;
    assign chosen_id   = cid_reg;
    assign chosen_type = ctype_reg;
    assign chosen_load = cload_reg;
    assign chosen_link = clink_reg;

    a_done_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_SCAN))
        else $error("result without a scan");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !found_reg) |->
        (cid_reg == '0 && ctype_reg == '0 && cload_reg == '0 && clink_reg == '0))
        else $error("not-found result carries data");

    a_pick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == CMD_PICK) |=> busy)
        else $error("pick taken without going busy");

    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vec))
        else $error("more than one token in the chain");

    a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_chain[TABLE_DEPTH].tok |-> (state_reg == ST_SCAN))
        else $error("token left the chain outside a scan");

    a_bump_with_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_op_reg == OP_BUMP) |-> (done_reg && found_reg))
        else $error("load bump without a found result");

endmodule

[verif/least_loaded_server_picker_top_tb.sv]
module least_loaded_server_picker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import llsp_pkg::*;

    localparam int DEPTH  = 64;
    localparam int TYPE_W = 16;
    localparam int LOAD_W = 20;
    localparam int LINK_W = 16;
    localparam logic [LOAD_W-1:0] LOAD_MAX = '1;
    localparam logic [TYPE_W-1:0] TYPE_ALL = '1;

    typedef struct
    {
        logic              found;
        logic [ID_BITS-1:0] id;
        logic [TYPE_W-1:0] typ;
        logic [LOAD_W-1:0] load;
        logic [LINK_W-1:0] link;
    } pick_result_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               command;
    logic [ID_BITS-1:0] server_id;
    logic [TYPE_W-1:0]  type_mask;
    logic [LOAD_W-1:0]  load_count;
    logic [LINK_W-1:0]  link_handle;
    logic               done;
    logic               found;
    logic [ID_BITS-1:0] chosen_id;
    logic [TYPE_W-1:0]  chosen_type;
    logic [LOAD_W-1:0]  chosen_load;
    logic [LINK_W-1:0]  chosen_link;

    bit                srv_valid[DEPTH];
    logic [TYPE_W-1:0] srv_types[DEPTH];
    logic [LOAD_W-1:0] srv_loads[DEPTH];
    logic [LINK_W-1:0] srv_links[DEPTH];

    pick_result_t pick_expect[$];
    int           error_count;
    bit           gaps_on;

    least_loaded_server_picker_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .server_id   (server_id),
        .type_mask   (type_mask),
        .load_count  (load_count),
        .link_handle (link_handle),
        .done        (done),
        .found       (found),
        .chosen_id   (chosen_id),
        .chosen_type (chosen_type),
        .chosen_load (chosen_load),
        .chosen_link (chosen_link)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    // Update the server table for one accepted word; queue the pick outcome.
    task automatic apply_word(input logic cmd, input logic [ID_BITS-1:0] id,
                              input logic [TYPE_W-1:0] mask,
                              input logic [LOAD_W-1:0] load,
                              input logic [LINK_W-1:0] link);
        pick_result_t res;
        int           best;
        bit           have;
        res  = '{found: 1'b0, id: '0, typ: '0, load: '0, link: '0};
        best = 0;
        have = 1'b0;
        if (cmd == CMD_SYNC)
        begin
            if (!srv_valid[id])
            begin
                srv_valid[id] = 1'b1;
                srv_types[id] = mask;
            end
            srv_loads[id] = load;
            srv_links[id] = link;
        end
        else
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (srv_valid[i] && (srv_types[i] & mask) != '0)
                begin
                    if (!have || srv_loads[i] < srv_loads[best])
                    begin
                        best = i;
                        have = 1'b1;
                    end
                end
            end
            if (have)
            begin
                if (srv_loads[best] != LOAD_MAX)
                    srv_loads[best] = srv_loads[best] + 1'b1;
                res.found = 1'b1;
                res.id    = best[ID_BITS-1:0];
                res.typ   = srv_types[best];
                res.load  = srv_loads[best];
                res.link  = srv_links[best];
            end
            pick_expect.push_back(res);
        end
    endtask

    task automatic send_word(input logic cmd, input logic [ID_BITS-1:0] id,
                             input logic [TYPE_W-1:0] mask,
                             input logic [LOAD_W-1:0] load,
                             input logic [LINK_W-1:0] link);
        @(negedge clk);
        start       = 1'b1;
        command     = cmd;
        server_id   = id;
        type_mask   = mask;
        load_count  = load;
        link_handle = link;
        do
            @(posedge clk);
        while (busy);
        apply_word(cmd, id, mask, load, link);
    endtask

    task automatic pause(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start       = 1'b0;
            command     = 1'($urandom_range(0, 1));
            server_id   = ID_BITS'($urandom);
            type_mask   = TYPE_W'($urandom);
            load_count  = LOAD_W'($urandom);
            link_handle = LINK_W'($urandom);
        end
    endtask

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 80);
    endfunction

    function automatic logic [TYPE_W-1:0] random_mask();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return TYPE_W'(1) << $urandom_range(0, TYPE_W - 1);
        if (r < 80)
            return TYPE_W'($urandom);
        if (r < 90)
            return TYPE_ALL;
        return '0;
    endfunction

    function automatic logic [LOAD_W-1:0] random_load(input bit heavy);
        int r;
        r = $urandom_range(0, 99);
        if (heavy || r < 20)
            return LOAD_MAX - LOAD_W'($urandom_range(0, 3));
        if (r < 60)
            return LOAD_W'($urandom_range(0, 15));
        return LOAD_W'($urandom);
    endfunction

    task automatic send_random(input int pick_pct, input bit heavy);
        logic cmd;
        cmd = ($urandom_range(0, 99) < pick_pct) ? CMD_PICK : CMD_SYNC;
        send_word(cmd, ID_BITS'($urandom), random_mask(), random_load(heavy),
                  LINK_W'($urandom));
        pause(random_gap());
    endtask

    // Empty table, field extremes, resync keeping type, saturation, ties.
    task automatic test_directed();
        send_word(CMD_PICK, '1, TYPE_ALL, LOAD_MAX, '1);
        send_word(CMD_PICK, '0, '0, '0, '0);
        send_word(CMD_SYNC, 6'd0, 16'h0001, LOAD_MAX, 16'hFFFF);
        send_word(CMD_SYNC, 6'd63, TYPE_ALL, '0, 16'h0000);
        send_word(CMD_SYNC, 6'd10, 16'h0000, '0, 16'h1234);
        send_word(CMD_PICK, '0, '0, '0, '0);
        send_word(CMD_PICK, '0, 16'h0001, '0, '0);
        send_word(CMD_PICK, '1, 16'h8000, LOAD_MAX, '1);
        send_word(CMD_SYNC, 6'd63, 16'h0002, LOAD_MAX, 16'hAAAA);
        send_word(CMD_PICK, '0, 16'h0001, '0, '0);
        send_word(CMD_PICK, '0, 16'h8000, '0, '0);
        send_word(CMD_PICK, '0, 16'h0002, '0, '0);
        send_word(CMD_SYNC, 6'd1, 16'h0001, 20'd5, 16'h5555);
        send_word(CMD_SYNC, 6'd2, 16'h0001, 20'd5, 16'h7777);
        send_word(CMD_PICK, '0, 16'h0001, '0, '0);
        send_word(CMD_PICK, '0, 16'h0001, '0, '0);
        send_word(CMD_PICK, '0, 16'h0001, '0, '0);
    endtask

    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 150 == 0)
                gaps_on = (i % 300 == 0);
            send_random(40, 1'b0);
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_saturation(input int count);
        for (int id = 0; id < DEPTH; id++)
            send_word(CMD_SYNC, ID_BITS'(id), random_mask(), random_load(1'b1),
                      LINK_W'($urandom));
        for (int i = 0; i < count; i++)
            send_random(80, 1'b1);
    endtask

    always @(posedge clk)
    begin : check_result
        pick_result_t exp;
        if (rst_n && done)
        begin
            if (pick_expect.size() == 0)
                report_mismatch("result with no pick pending");
            else
            begin
                exp = pick_expect.pop_front();
                if (found !== exp.found)
                    report_mismatch($sformatf("found %0b, want %0b", found, exp.found));
                if (chosen_id !== exp.id)
                    report_mismatch($sformatf("chosen_id %0d, want %0d", chosen_id, exp.id));
                if (chosen_type !== exp.typ)
                    report_mismatch($sformatf("chosen_type %h, want %h",
                                              chosen_type, exp.typ));
                if (chosen_load !== exp.load)
                    report_mismatch($sformatf("chosen_load %h, want %h",
                                              chosen_load, exp.load));
                if (chosen_link !== exp.link)
                    report_mismatch($sformatf("chosen_link %h, want %h",
                                              chosen_link, exp.link));
            end
        end
    end

    initial
    begin
        error_count = 0;
        gaps_on     = 1'b1;
        rst_n       = 1'b0;
        start       = 1'b0;
        command     = CMD_SYNC;
        server_id   = '0;
        type_mask   = '0;
        load_count  = '0;
        link_handle = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_mix(1220);
        test_saturation(250);

        @(negedge clk);
        start = 1'b0;
        while (pick_expect.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
